>>> rtl/pbdc_pkg.sv
// Shared types and constants for the boost PFC duty calculator.
package pbdc_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_MIN_DIV  = 3'd0;
  localparam logic [2:0] REG_FULL     = 3'd1;
  localparam logic [2:0] REG_ZERO     = 3'd2;
  localparam logic [2:0] REG_MIN_DUTY = 3'd3;
  localparam logic [2:0] REG_MAX_DUTY = 3'd4;
  localparam logic [2:0] REG_DEAD     = 3'd5;

  // Register reset values
  localparam logic [14:0] RST_MIN_DIV  = 15'd1024;
  localparam logic [14:0] RST_FULL     = 15'd4096;
  localparam logic [14:0] RST_ZERO     = 15'd0;
  localparam logic [14:0] RST_MIN_DUTY = 15'd40;
  localparam logic [15:0] RST_MAX_DUTY = 16'd4056;
  localparam logic [11:0] RST_DEAD     = 12'd20;

  // Divider geometry: 16 quotient bits, two restoring steps per stage
  localparam int QUO_BITS   = 16;
  localparam int DIV_STEP   = 2;
  localparam int DIV_STAGES = QUO_BITS / DIV_STEP;
  localparam int MAG_W      = 31;   // |(va << 15) + 16384| <= 2^30
  localparam int DVS_W      = 15;

  // Front stages, divider stages, back stages
  localparam int FRONT_STAGES = 3;
  localparam int BACK_STAGES  = 4;
  localparam int PIPE_DEPTH   = FRONT_STAGES + DIV_STAGES + BACK_STAGES;

  // Word carried through the divider stages
  typedef struct packed {
    logic             neg;     // numerator negative
    logic             va_pos;  // command > 0
    logic             ia_pos;  // current > 0
    logic             ovf;     // quotient magnitude >= 2^16
    logic [DVS_W-1:0] dvs;     // divisor, 1..32767
    logic [MAG_W-1:0] rem;     // partial remainder
    logic [QUO_BITS-1:0] quo;  // quotient magnitude bits
  } div_word_t;

endpackage

>>> rtl/pfc_boost_duty_calc_unit.sv
// Top level of the boost PFC duty calculator: pipelined divide, scale and limit.
//
// Accepts one input word per clock and returns one result word per input word,
// in order. A result word is presented on the output once its input word has passed
// through every pipeline stage register, and new words are taken while earlier ones
// are in flight. Throughput is one word per cycle while the output side does not stall. The
// pipeline is 3 front stages (numerator and divisor select, magnitude, overflow
// check), 8 divider stages of two restoring subtract steps each for the 16
// quotient bits, and 4 back stages (saturation, 16x16 multiply, rounding shift
// with dead-time, duty limits).
// When a result word waits at the output and is not taken, the whole pipeline
// holds and in_ready drops. Configuration registers are read directly by the stages
// that use them, so write them only while no word is in flight.
module pfc_boost_duty_calc_unit (
  input  logic               clk,
  input  logic               rst,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] voltage_command,
  input  logic signed [15:0] output_voltage,
  input  logic signed [15:0] input_current,
  // output channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        duty_compare,
  output logic [14:0]        leg_level,
  // configuration write port
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int DEPTH   = pbdc_pkg::PIPE_DEPTH;
  localparam int NDIV    = pbdc_pkg::DIV_STAGES;
  localparam int QB      = pbdc_pkg::QUO_BITS;
  localparam int MW      = pbdc_pkg::MAG_W;
  localparam int DW      = pbdc_pkg::DVS_W;
  // valid bit positions
  localparam int V_DIV_LAST = pbdc_pkg::FRONT_STAGES - 1 + NDIV;
  localparam int V_SAT      = V_DIV_LAST + 1;

  // configuration registers
  logic [14:0] min_div;
  logic [14:0] full_cnt;
  logic [14:0] zero_cnt;
  logic [14:0] min_duty;
  logic [15:0] max_duty;
  logic [11:0] dead_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_div  <= pbdc_pkg::RST_MIN_DIV;
      full_cnt <= pbdc_pkg::RST_FULL;
      zero_cnt <= pbdc_pkg::RST_ZERO;
      min_duty <= pbdc_pkg::RST_MIN_DUTY;
      max_duty <= pbdc_pkg::RST_MAX_DUTY;
      dead_cnt <= pbdc_pkg::RST_DEAD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pbdc_pkg::REG_MIN_DIV:  min_div  <= cfg_data[14:0];
        pbdc_pkg::REG_FULL:     full_cnt <= cfg_data[14:0];
        pbdc_pkg::REG_ZERO:     zero_cnt <= cfg_data[14:0];
        pbdc_pkg::REG_MIN_DUTY: min_duty <= cfg_data[14:0];
        pbdc_pkg::REG_MAX_DUTY: max_duty <= cfg_data;
        pbdc_pkg::REG_DEAD:     dead_cnt <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // pipeline control: every stage moves unless the output word is held
  logic             advance;
  logic [DEPTH-1:0] vld;

  assign advance   = !vld[DEPTH-1] || out_ready;
  assign in_ready  = advance;
  assign out_valid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[DEPTH-2:0], in_valid};
    end
  end

  // stage 1: numerator and divisor select
  logic signed [31:0] s1_num;
  logic [DW-1:0]      s1_dvs;
  logic               s1_va_pos;
  logic               s1_ia_pos;
  logic [DW-1:0]      dvs_sel;

  always_comb begin
    if (output_voltage < $signed({1'b0, min_div})) begin
      dvs_sel = min_div;
    end else begin
      dvs_sel = output_voltage[DW-1:0];
    end
    if (dvs_sel == '0) begin
      dvs_sel = DW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      // (va << 15) + 16384, sign-extended to 32 bits
      s1_num    <= {voltage_command[15], voltage_command, 15'h4000};
      s1_dvs    <= dvs_sel;
      s1_va_pos <= voltage_command > 16'sd0;
      s1_ia_pos <= input_current > 16'sd0;
    end
  end

  // stage 2: numerator magnitude
  logic          s2_neg;
  logic [MW-1:0] s2_mag;
  logic [DW-1:0] s2_dvs;
  logic          s2_va_pos;
  logic          s2_ia_pos;
  logic [31:0]   num_abs;

  assign num_abs = s1_num[31] ? 32'(-s1_num) : 32'(s1_num);

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_neg    <= s1_num[31];
      s2_mag    <= num_abs[MW-1:0];
      s2_dvs    <= s1_dvs;
      s2_va_pos <= s1_va_pos;
      s2_ia_pos <= s1_ia_pos;
    end
  end

  // stage 3: quotient overflow check, divider entry
  pbdc_pkg::div_word_t dstg [NDIV+1];

  always_ff @(posedge clk) begin
    if (advance) begin
      dstg[0].neg    <= s2_neg;
      dstg[0].va_pos <= s2_va_pos;
      dstg[0].ia_pos <= s2_ia_pos;
      dstg[0].ovf    <= s2_mag >= {s2_dvs, {QB{1'b0}}};
      dstg[0].dvs    <= s2_dvs;
      dstg[0].rem    <= s2_mag;
      dstg[0].quo    <= '0;
    end
  end

  // divider stages: restoring steps, most significant quotient bit first
  for (genvar j = 0; j < NDIV; j++) begin : g_div
    pbdc_pkg::div_word_t nxt;

    always_comb begin
      logic [MW-1:0] r;
      logic [MW-1:0] sh;
      nxt = dstg[j];
      r   = dstg[j].rem;
      for (int b = 0; b < pbdc_pkg::DIV_STEP; b++) begin
        sh = {{(MW-DW){1'b0}}, dstg[j].dvs} << (QB - 1 - j * pbdc_pkg::DIV_STEP - b);
        if (r >= sh) begin
          r = r - sh;
          nxt.quo[QB - 1 - j * pbdc_pkg::DIV_STEP - b] = 1'b1;
        end
      end
      nxt.rem = r;
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        dstg[j+1] <= nxt;
      end
    end
  end

  // back stage 1: sign and saturate to 16 bits
  logic signed [15:0] p1_t;
  logic               p1_va_pos;
  logic               p1_ia_pos;
  logic signed [15:0] sat_t;
  logic signed [16:0] neg_q;

  always_comb begin
    neg_q = -$signed({1'b0, dstg[NDIV].quo});
    if (!dstg[NDIV].neg) begin
      if (dstg[NDIV].ovf || dstg[NDIV].quo[QB-1]) begin
        sat_t = 16'sh7FFF;
      end else begin
        sat_t = $signed(dstg[NDIV].quo);
      end
    end else begin
      if (dstg[NDIV].ovf || dstg[NDIV].quo > 16'h8000) begin
        sat_t = -16'sh8000;
      end else begin
        sat_t = neg_q[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p1_t      <= sat_t;
      p1_va_pos <= dstg[NDIV].va_pos;
      p1_ia_pos <= dstg[NDIV].ia_pos;
    end
  end

  // back stage 2: scale by full duty count
  logic signed [31:0] p2_prod;
  logic               p2_va_pos;
  logic               p2_ia_pos;

  always_ff @(posedge clk) begin
    if (advance) begin
      p2_prod   <= 32'(p1_t) * 32'($signed({1'b0, full_cnt}));
      p2_va_pos <= p1_va_pos;
      p2_ia_pos <= p1_ia_pos;
    end
  end

  // back stage 3: round, floor shift, dead-time compensation
  logic signed [17:0] p3_t;
  logic               p3_va_pos;
  logic signed [31:0] rnd;
  logic signed [17:0] shf;
  logic signed [17:0] dt_s;

  always_comb begin
    rnd  = p2_prod + 32'sd16384;
    shf  = 18'($signed(rnd[31:15]));
    dt_s = $signed({6'd0, dead_cnt});
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p3_t      <= p2_ia_pos ? (shf - dt_s) : (shf + dt_s);
      p3_va_pos <= p2_va_pos;
    end
  end

  // back stage 4: duty limits and leg level
  logic signed [18:0] off_t;
  logic signed [18:0] lim_t;
  logic [14:0]        leg_next;

  always_comb begin
    off_t = 19'(p3_t) + $signed({4'd0, full_cnt});
    if (p3_va_pos) begin
      leg_next = zero_cnt;
      if (p3_t < $signed({3'd0, min_duty})) begin
        lim_t = $signed({4'd0, min_duty});
      end else begin
        lim_t = 19'(p3_t);
      end
    end else begin
      leg_next = full_cnt;
      if (off_t > $signed({3'd0, max_duty})) begin
        lim_t = $signed({3'd0, max_duty});
      end else if (off_t < $signed({4'd0, zero_cnt})) begin
        lim_t = $signed({4'd0, zero_cnt});
      end else begin
        lim_t = off_t;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      duty_compare <= lim_t[15:0];
      leg_level    <= leg_next;
    end
  end

  // checks
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(vld))
    else $error("pipeline moved during output stall");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    vld[V_DIV_LAST] && !dstg[NDIV].ovf |-> dstg[NDIV].rem < {{(MW-DW){1'b0}}, dstg[NDIV].dvs})
    else $error("divider remainder not below divisor");

  // a positive command gives a positive numerator, so the quotient is not negative
  a_sat_sign: assert property (@(posedge clk) disable iff (rst)
    vld[V_SAT] && p1_va_pos |-> p1_t >= 16'sd0)
    else $error("negative quotient for positive command");

  a_leg_level: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (leg_level == zero_cnt || leg_level == full_cnt))
    else $error("leg level not a configured count");

endmodule
